// ===== rtl/lbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbs_pkg: shared types and constants for the skinning engine
// Matrix table geometry, stream word layout, fixed-point widths and the
// control and result structs passed between the control and the datapath.
// ----------------------------------------------------------------------------
package lbs_pkg;

    // Matrix table
    localparam int MAX_JOINTS = 32;
    localparam int MAT_ELEMS  = 12;
    localparam int MAT_DEPTH  = MAX_JOINTS * MAT_ELEMS;
    localparam int MAT_AW     = $clog2(MAT_DEPTH);
    localparam logic [3:0] LAST_ELEM = 4'(MAT_ELEMS - 1);

    // Field widths
    localparam int JOINT_W   = 5;
    localparam int ELEM_W    = 4;
    localparam int COORD_W   = 32;
    localparam int WEIGHT_W  = 17;
    localparam int WSUM_W    = 22;

    // Arithmetic widths
    localparam int PROD_W    = 2 * COORD_W;          // coef * point
    localparam int SUM_W     = PROD_W + 2;           // three products plus rounding
    localparam int Q_W       = SUM_W - 16 + 1;       // Q16.16 row value plus offset
    localparam int CONTRIB_W = COORD_W + WEIGHT_W + 1;
    localparam int ACC_W     = 64;
    localparam int RND_W     = ACC_W - 16 + 1;

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0]   ACC_MAX   = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0]   ACC_MIN   = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [WSUM_W-1:0]         WSUM_MAX  = {WSUM_W{1'b1}};
    localparam logic signed [SUM_W-1:0]   ROUND_HALF = SUM_W'(32768);

    // Slave-side word layout
    localparam int S_TDATA_W  = 160;
    localparam int S_TUSER_W  = 2;
    localparam int JOINT_LSB  = 0;
    localparam int ELEM_LSB   = JOINT_LSB + JOINT_W;
    localparam int COEF_LSB   = ELEM_LSB + ELEM_W;
    localparam int PX_LSB     = COEF_LSB + COORD_W;
    localparam int PY_LSB     = PX_LSB + COORD_W;
    localparam int PZ_LSB     = PY_LSB + COORD_W;
    localparam int WEIGHT_LSB = PZ_LSB + COORD_W;
    localparam int OP_BIT     = 0;
    localparam int LAST_VERTEX_BIT = 1;

    // Master-side word layout
    localparam int M_TDATA_W = 120;
    localparam int M_PAD_W   = M_TDATA_W - 3 * COORD_W - WSUM_W;

    // Operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_ADD  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT
    } lbs_state_t;

    // Tag that travels with each coefficient read
    typedef struct packed {
        logic       valid;
        logic [1:0] row;
        logic [1:0] col;
    } lbs_tok_t;

    typedef struct packed {
        lbs_tok_t tok;
        logic     add_w;
        logic     clear;
    } lbs_ctrl_t;

    typedef struct packed {
        logic [WSUM_W-1:0]         w;
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } lbs_result_t;

endpackage

// ===== rtl/linear_blend_skinning.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_blend_skinning: linear blend skinning engine
// A matrix load word with a valid joint and element is written into the table
// while idle. A contribution word issues 12 coefficient reads from the single
// read port of the matrix memory, then drains until the last row reaches the
// accumulators; a last-joint word then hands the blended vertex to the output register, waiting while it is still full.
// Reset clears the accumulators and control; the matrix table is undefined
// until written.
// ----------------------------------------------------------------------------
module linear_blend_skinning (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // joint, element, coef, px, py, pz, weight, zero fill
    input  logic [lbs_pkg::S_TDATA_W-1:0]     s_tdata,
    // operation, last_vertex
    input  logic [lbs_pkg::S_TUSER_W-1:0]     s_tuser,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_x, out_y, out_z, out_w, zero fill
    output logic [lbs_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tlast
);

    lbs_pkg::lbs_state_t                  state_reg;
    lbs_pkg::lbs_state_t                  state_next;
    logic [3:0]                           cnt_reg;
    logic [3:0]                           cnt_next;
    logic [lbs_pkg::MAT_AW-1:0]           base_reg;
    logic signed [lbs_pkg::COORD_W-1:0]   px_reg;
    logic signed [lbs_pkg::COORD_W-1:0]   py_reg;
    logic signed [lbs_pkg::COORD_W-1:0]   pz_reg;
    logic [lbs_pkg::WEIGHT_W-1:0]         weight_reg;
    logic                                 last_joint_reg;
    logic                                 last_vertex_reg;
    lbs_pkg::lbs_tok_t                    tok_reg;
    lbs_pkg::lbs_ctrl_t                   ctrl;
    logic                                 m_tvalid_reg;
    logic [lbs_pkg::M_TDATA_W-1:0]        m_tdata_reg;
    logic                                 m_tlast_reg;

    logic                                 in_accept;
    logic                                 in_op;
    logic [lbs_pkg::JOINT_W-1:0]          in_joint;
    logic [lbs_pkg::ELEM_W-1:0]           in_element;
    logic                                 joint_ok;
    logic                                 elem_ok;
    logic                                 accept_add;
    logic                                 mem_we;
    logic [lbs_pkg::MAT_AW-1:0]           mem_waddr;
    logic                                 mem_re;
    logic [lbs_pkg::MAT_AW-1:0]           mem_raddr;
    logic [lbs_pkg::COORD_W-1:0]          mem_rdata;
    logic                                 out_free;
    logic                                 emit;
    logic                                 dp_done;
    lbs_pkg::lbs_result_t                 dp_result;

    assign s_tready   = (state_reg == lbs_pkg::ST_IDLE);
    assign in_accept  = s_tvalid && s_tready;
    assign in_op      = s_tuser[lbs_pkg::OP_BIT];
    assign in_joint   = s_tdata[lbs_pkg::JOINT_LSB +: lbs_pkg::JOINT_W];
    assign in_element = s_tdata[lbs_pkg::ELEM_LSB +: lbs_pkg::ELEM_W];
    assign joint_ok   = int'(in_joint) < lbs_pkg::MAX_JOINTS;
    assign elem_ok    = int'(in_element) < lbs_pkg::MAT_ELEMS;
    assign accept_add = in_accept && (in_op == lbs_pkg::OP_ADD);

    // Loads write only in idle, reads only while issuing: no port conflict
    assign mem_we    = in_accept && (in_op == lbs_pkg::OP_LOAD) && joint_ok && elem_ok;
    assign mem_waddr = lbs_pkg::MAT_AW'(int'(in_joint) * lbs_pkg::MAT_ELEMS
                                        + int'(in_element));
    assign mem_re    = (state_reg == lbs_pkg::ST_ISSUE);
    assign mem_raddr = base_reg + lbs_pkg::MAT_AW'(cnt_reg);

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        emit       = 1'b0;
        case (state_reg)
            lbs_pkg::ST_IDLE:
            begin
                if (accept_add)
                begin
                    if (joint_ok)
                        state_next = lbs_pkg::ST_ISSUE;
                    else if (s_tlast)
                        state_next = lbs_pkg::ST_EMIT;
                end
            end
            lbs_pkg::ST_ISSUE:
            begin
                if (cnt_reg == lbs_pkg::LAST_ELEM)
                begin
                    cnt_next   = 4'd0;
                    state_next = lbs_pkg::ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            lbs_pkg::ST_DRAIN:
            begin
                if (dp_done)
                    state_next = last_joint_reg ? lbs_pkg::ST_EMIT : lbs_pkg::ST_IDLE;
            end
            lbs_pkg::ST_EMIT:
            begin
                // hold until the output register frees up
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = lbs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lbs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lbs_pkg::ST_IDLE;
            cnt_reg      <= 4'd0;
            tok_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            tok_reg.valid <= mem_re;
            tok_reg.row   <= cnt_reg[3:2];
            tok_reg.col   <= cnt_reg[1:0];
            if (emit)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // Hold the item for the duration of its transform
    always_ff @(posedge clk)
    begin
        if (accept_add)
        begin
            base_reg        <= lbs_pkg::MAT_AW'(int'(in_joint) * lbs_pkg::MAT_ELEMS);
            px_reg          <= s_tdata[lbs_pkg::PX_LSB +: lbs_pkg::COORD_W];
            py_reg          <= s_tdata[lbs_pkg::PY_LSB +: lbs_pkg::COORD_W];
            pz_reg          <= s_tdata[lbs_pkg::PZ_LSB +: lbs_pkg::COORD_W];
            weight_reg      <= s_tdata[lbs_pkg::WEIGHT_LSB +: lbs_pkg::WEIGHT_W];
            last_joint_reg  <= s_tlast;
            last_vertex_reg <= s_tuser[lbs_pkg::LAST_VERTEX_BIT];
        end
        if (emit)
        begin
            m_tdata_reg <= {{lbs_pkg::M_PAD_W{1'b0}}, dp_result.w, dp_result.z,
                            dp_result.y, dp_result.x};
            m_tlast_reg <= last_vertex_reg;
        end
    end

    always_comb
    begin
        ctrl.tok   = tok_reg;
        ctrl.add_w = (state_reg == lbs_pkg::ST_ISSUE) && (cnt_reg == 4'd0);
        ctrl.clear = emit;
    end

    lbs_coef_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (s_tdata[lbs_pkg::COEF_LSB +: lbs_pkg::COORD_W]),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    lbs_blend_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .coef   (mem_rdata),
        .px     (px_reg),
        .py     (py_reg),
        .pz     (pz_reg),
        .weight (weight_reg),
        .done   (dp_done),
        .result (dp_result)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_wr_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (!mem_re && !tok_reg.valid))
        else $error("matrix write overlaps a coefficient read");

    a_done_drain: assert property (@(posedge clk) disable iff (!rst_n)
        dp_done |-> (state_reg == lbs_pkg::ST_DRAIN))
        else $error("datapath finished outside of drain");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (m_tvalid && (state_reg == lbs_pkg::ST_IDLE)))
        else $error("emitted vertex not presented");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (in_op == lbs_pkg::OP_LOAD)) |=> (state_reg == lbs_pkg::ST_IDLE))
        else $error("load word left idle");

endmodule

// ===== rtl/lbs_coef_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbs_coef_mem: joint matrix coefficient store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lbs_coef_mem (
    input  logic                          clk,
    input  logic                          we,
    input  logic [lbs_pkg::MAT_AW-1:0]    waddr,
    input  logic [lbs_pkg::COORD_W-1:0]   wdata,
    input  logic                          re,
    input  logic [lbs_pkg::MAT_AW-1:0]    raddr,
    output logic [lbs_pkg::COORD_W-1:0]   rdata
);

    logic [lbs_pkg::COORD_W-1:0] mem [lbs_pkg::MAT_DEPTH];
    logic [lbs_pkg::COORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/lbs_blend_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbs_blend_dp: transform, weight and accumulate datapath
// Takes one coefficient per cycle, builds each row of the affine transform,
// scales it by the weight and adds it into saturating 64-bit accumulators.
// ----------------------------------------------------------------------------
module lbs_blend_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  lbs_pkg::lbs_ctrl_t                    ctrl,
    input  logic signed [lbs_pkg::COORD_W-1:0]    coef,
    input  logic signed [lbs_pkg::COORD_W-1:0]    px,
    input  logic signed [lbs_pkg::COORD_W-1:0]    py,
    input  logic signed [lbs_pkg::COORD_W-1:0]    pz,
    input  logic [lbs_pkg::WEIGHT_W-1:0]          weight,
    output logic                                  done,
    output lbs_pkg::lbs_result_t                  result
);

    function automatic logic signed [lbs_pkg::COORD_W-1:0] sat_row(
        input logic signed [lbs_pkg::Q_W-1:0] v);
        logic signed [lbs_pkg::COORD_W-1:0] r;
        if (v[lbs_pkg::Q_W-1:lbs_pkg::COORD_W-1] ==
            {(lbs_pkg::Q_W-lbs_pkg::COORD_W+1){v[lbs_pkg::Q_W-1]}})
            r = v[lbs_pkg::COORD_W-1:0];
        else
            r = v[lbs_pkg::Q_W-1] ? lbs_pkg::COORD_MIN : lbs_pkg::COORD_MAX;
        return r;
    endfunction

    function automatic logic signed [lbs_pkg::ACC_W-1:0] sat_add(
        input logic signed [lbs_pkg::ACC_W-1:0] a,
        input logic signed [lbs_pkg::ACC_W-1:0] b);
        logic [lbs_pkg::ACC_W:0]            s;
        logic signed [lbs_pkg::ACC_W-1:0]   r;
        s = {a[lbs_pkg::ACC_W-1], a} + {b[lbs_pkg::ACC_W-1], b};
        if (s[lbs_pkg::ACC_W] != s[lbs_pkg::ACC_W-1])
            r = s[lbs_pkg::ACC_W] ? lbs_pkg::ACC_MIN : lbs_pkg::ACC_MAX;
        else
            r = s[lbs_pkg::ACC_W-1:0];
        return r;
    endfunction

    // Q32.32 to Q16.16, nearest with ties up, then saturate
    function automatic logic signed [lbs_pkg::COORD_W-1:0] round_acc(
        input logic signed [lbs_pkg::ACC_W-1:0] a);
        logic [lbs_pkg::RND_W-1:0]            q;
        logic signed [lbs_pkg::COORD_W-1:0]   r;
        q = {a[lbs_pkg::ACC_W-1], a[lbs_pkg::ACC_W-1:16]} + lbs_pkg::RND_W'(a[15]);
        if (q[lbs_pkg::RND_W-1:lbs_pkg::COORD_W-1] ==
            {(lbs_pkg::RND_W-lbs_pkg::COORD_W+1){q[lbs_pkg::RND_W-1]}})
            r = q[lbs_pkg::COORD_W-1:0];
        else
            r = q[lbs_pkg::RND_W-1] ? lbs_pkg::COORD_MIN : lbs_pkg::COORD_MAX;
        return r;
    endfunction

    logic signed [lbs_pkg::COORD_W-1:0]    psel;
    logic signed [lbs_pkg::PROD_W-1:0]     mul_reg;
    logic signed [lbs_pkg::COORD_W-1:0]    m3_reg;
    lbs_pkg::lbs_tok_t                     s1_reg;
    logic signed [lbs_pkg::SUM_W-1:0]      sum_reg;
    logic signed [lbs_pkg::SUM_W-1:0]      prod_ext;
    logic signed [lbs_pkg::Q_W-1:0]        q_reg;
    logic                                  s2_valid_reg;
    logic [1:0]                            s2_row_reg;
    logic signed [lbs_pkg::COORD_W-1:0]    t_reg;
    logic                                  s3_valid_reg;
    logic [1:0]                            s3_row_reg;
    logic signed [lbs_pkg::CONTRIB_W-1:0]  contrib_reg;
    logic                                  s4_valid_reg;
    logic [1:0]                            s4_row_reg;
    logic signed [lbs_pkg::ACC_W-1:0]      acc_x_reg;
    logic signed [lbs_pkg::ACC_W-1:0]      acc_y_reg;
    logic signed [lbs_pkg::ACC_W-1:0]      acc_z_reg;
    logic [lbs_pkg::WSUM_W-1:0]            acc_w_reg;
    logic signed [lbs_pkg::ACC_W-1:0]      acc_sel;
    logic signed [lbs_pkg::ACC_W-1:0]      acc_new;
    logic [lbs_pkg::WSUM_W:0]              wsum;

    always_comb
    begin
        case (ctrl.tok.col)
            2'd0:    psel = px;
            2'd1:    psel = py;
            default: psel = pz;
        endcase
    end

    assign prod_ext = {{(lbs_pkg::SUM_W-lbs_pkg::PROD_W){mul_reg[lbs_pkg::PROD_W-1]}},
                       mul_reg};

    // Stage 1: one coefficient product per cycle, offset column held aside
    always_ff @(posedge clk)
    begin
        if (ctrl.tok.valid)
        begin
            if (ctrl.tok.col == 2'd3)
                m3_reg <= coef;
            else
                mul_reg <= lbs_pkg::PROD_W'(coef) * lbs_pkg::PROD_W'(psel);
        end
    end

    // Stage 2: row sum, then shift to Q16.16 and add the offset
    always_ff @(posedge clk)
    begin
        if (s1_reg.valid)
        begin
            case (s1_reg.col)
                2'd0:    sum_reg <= prod_ext + lbs_pkg::ROUND_HALF;
                2'd3:    q_reg <= {sum_reg[lbs_pkg::SUM_W-1], sum_reg[lbs_pkg::SUM_W-1:16]}
                                + {{(lbs_pkg::Q_W-lbs_pkg::COORD_W){m3_reg[lbs_pkg::COORD_W-1]}},
                                   m3_reg};
                default: sum_reg <= sum_reg + prod_ext;
            endcase
        end
        if (s2_valid_reg)
            t_reg <= sat_row(q_reg);
        if (s3_valid_reg)
            contrib_reg <= lbs_pkg::CONTRIB_W'(t_reg)
                         * lbs_pkg::CONTRIB_W'($signed({1'b0, weight}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg       <= '0;
            s2_valid_reg <= 1'b0;
            s2_row_reg   <= 2'd0;
            s3_valid_reg <= 1'b0;
            s3_row_reg   <= 2'd0;
            s4_valid_reg <= 1'b0;
            s4_row_reg   <= 2'd0;
        end
        else
        begin
            s1_reg       <= ctrl.tok;
            s2_valid_reg <= s1_reg.valid && (s1_reg.col == 2'd3);
            s2_row_reg   <= s1_reg.row;
            s3_valid_reg <= s2_valid_reg;
            s3_row_reg   <= s2_row_reg;
            s4_valid_reg <= s3_valid_reg;
            s4_row_reg   <= s3_row_reg;
        end
    end

    always_comb
    begin
        case (s4_row_reg)
            2'd0:    acc_sel = acc_x_reg;
            2'd1:    acc_sel = acc_y_reg;
            default: acc_sel = acc_z_reg;
        endcase
        acc_new = sat_add(acc_sel,
                          {{(lbs_pkg::ACC_W-lbs_pkg::CONTRIB_W){contrib_reg[lbs_pkg::CONTRIB_W-1]}},
                           contrib_reg});
        wsum = {1'b0, acc_w_reg} + (lbs_pkg::WSUM_W+1)'(weight);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_x_reg <= '0;
            acc_y_reg <= '0;
            acc_z_reg <= '0;
            acc_w_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            acc_x_reg <= '0;
            acc_y_reg <= '0;
            acc_z_reg <= '0;
            acc_w_reg <= '0;
        end
        else
        begin
            if (s4_valid_reg)
            begin
                case (s4_row_reg)
                    2'd0:    acc_x_reg <= acc_new;
                    2'd1:    acc_y_reg <= acc_new;
                    default: acc_z_reg <= acc_new;
                endcase
            end
            if (ctrl.add_w)
                acc_w_reg <= wsum[lbs_pkg::WSUM_W] ? lbs_pkg::WSUM_MAX
                                                   : wsum[lbs_pkg::WSUM_W-1:0];
        end
    end

    assign done     = s4_valid_reg && (s4_row_reg == 2'd2);
    assign result.x = round_acc(acc_x_reg);
    assign result.y = round_acc(acc_y_reg);
    assign result.z = round_acc(acc_z_reg);
    assign result.w = acc_w_reg;

endmodule
